// ----- rtl/postfix_stack_evaluator_core_assert.svh -----
// Assertion macros for the postfix evaluator core.
// Included by the top level only; no other dependencies.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH

// Implication checked every clock, off during reset.
`define PSE_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pse check failed");

// Next-cycle implication, off during reset.
`define PSE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pse check failed");

`endif

// ----- rtl/pse_pkg.sv -----
// Package for the postfix evaluator: token and error codes, payload structs.
// No dependencies.
package pse_pkg;

   localparam int unsigned STACK_DEPTH_DEF = 64;
   localparam int unsigned DATA_W          = 32;
   localparam int unsigned COUNT_W         = 7;

   typedef enum logic [2:0] {
      TK_NUM = 3'd0,
      TK_ADD = 3'd1,
      TK_SUB = 3'd2,
      TK_MUL = 3'd3,
      TK_DIV = 3'd4,
      TK_POW = 3'd5,
      TK_END = 3'd6,
      TK_BAD = 3'd7
   } tok_type;

   typedef enum logic [2:0] {
      ERR_OK            = 3'd0,
      ERR_FEW_OPERANDS  = 3'd1,
      ERR_DIV_ZERO      = 3'd2,
      ERR_ZERO_ZERO     = 3'd3,
      ERR_FEW_OPERATORS = 3'd4,
      ERR_BAD_TOKEN     = 3'd5,
      ERR_OVERFLOW      = 3'd6
   } err_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [2:0]         error_code;
      logic               expr_done;
      logic [6:0]         stack_count;
   } rsp_type;

   // ALU command from sequencer
   typedef struct packed {
      logic       start;
      logic [2:0] op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] res;
      logic [2:0]  err;
   } alu_rsp_type;

endpackage

// ----- rtl/postfix_stack_evaluator_core.sv -----
// Top level of the postfix evaluator: sequencer, operand stack memory, ALU.
// Depends on pse_pkg, pse_alu and postfix_stack_evaluator_core_assert.svh.
//
//   channel | dir | payload            | handshake
//   req_    | in  | pse_pkg::req_type  | req_valid / req_ready
//   rsp_    | out | pse_pkg::rsp_type  | rsp_valid / rsp_ready
//
// One token at a time. Number and error tokens go straight to the response, end
// via one read of entry 0; add, sub, mul and failed operators take one ALU pass;
// div one quotient bit a cycle; power a multiply and square per bit on the one multiplier.
// Operands come from a stack memory with one read port, two reads before the ALU runs.
// Reset clears pointer, latched error and control; stack contents are not.
// The next token is taken once the result transfer is done; rsp_ready low adds cycles.
`include "postfix_stack_evaluator_core_assert.svh"
module postfix_stack_evaluator_core #(
   parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pse_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pse_pkg::rsp_type  rsp_data
);

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {S_IDLE, S_RDB, S_RDA, S_RUN, S_WAIT, S_WR, S_RSP}
      st_type;

   st_type      state_ff;
   logic [PW-1:0] sp_ff;
   logic [2:0]  err_ff;
   logic [2:0]  op_ff;
   logic [31:0] opb_ff;
   pse_pkg::rsp_type rsp_ff;

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rd_ff;
   logic        we;
   logic [AW-1:0] waddr, raddr;
   logic [31:0] wdata;

   pse_pkg::alu_cmd_type cmd;
   pse_pkg::alu_rsp_type arsp;

   pse_alu u_alu (.clock(clock), .reset(reset), .cmd(cmd), .rsp(arsp));

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_comb begin
      raddr = AW'(sp_ff - PW'(1));
      // left operand is read in RDB and held through RDA
      if (state_ff == S_RDB || state_ff == S_RDA) raddr = AW'(sp_ff - PW'(2));
      if (state_ff == S_IDLE && req_data.func == pse_pkg::TK_END) raddr = '0;
      we    = 1'b0;
      waddr = AW'(sp_ff);
      wdata = req_data.value;
      if (state_ff == S_IDLE && req_valid && err_ff == pse_pkg::ERR_OK &&
          req_data.func == pse_pkg::TK_NUM && 32'(sp_ff) < STACK_DEPTH) begin
         we = 1'b1;
      end
      if (state_ff == S_WR) begin
         we    = arsp.done && (arsp.err == pse_pkg::ERR_OK);
         waddr = AW'(sp_ff - PW'(2));
         wdata = arsp.res;
      end
   end

   assign cmd.start = (state_ff == S_RUN);
   assign cmd.op    = op_ff;
   assign cmd.a     = rd_ff;
   assign cmd.b     = opb_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
         err_ff   <= pse_pkg::ERR_OK;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_data.func;
                  rsp_ff.result_value <= '0;
                  rsp_ff.expr_done    <= 1'b0;
                  state_ff <= S_RSP;
                  if (req_data.func == pse_pkg::TK_END) begin
                     rsp_ff.expr_done <= 1'b1;
                     state_ff <= S_WAIT;  // wait for read of entry 0
                  end else if (err_ff != pse_pkg::ERR_OK) begin
                     rsp_ff.error_code  <= err_ff;
                     rsp_ff.stack_count <= 7'(sp_ff);
                  end else begin
                     case (req_data.func)
                        pse_pkg::TK_NUM: begin
                           if (32'(sp_ff) < STACK_DEPTH) begin
                              sp_ff <= sp_ff + PW'(1);
                              rsp_ff.error_code  <= pse_pkg::ERR_OK;
                              rsp_ff.stack_count <= 7'(sp_ff + PW'(1));
                           end else begin
                              err_ff <= pse_pkg::ERR_OVERFLOW;
                              sp_ff  <= '0;
                              rsp_ff.error_code  <= pse_pkg::ERR_OVERFLOW;
                              rsp_ff.stack_count <= '0;
                           end
                        end
                        pse_pkg::TK_ADD, pse_pkg::TK_SUB, pse_pkg::TK_MUL,
                        pse_pkg::TK_DIV, pse_pkg::TK_POW: begin
                           if (sp_ff < PW'(2)) begin
                              err_ff <= pse_pkg::ERR_FEW_OPERANDS;
                              sp_ff  <= '0;
                              rsp_ff.error_code  <= pse_pkg::ERR_FEW_OPERANDS;
                              rsp_ff.stack_count <= '0;
                           end else begin
                              state_ff <= S_RDB;
                           end
                        end
                        default: begin
                           err_ff <= pse_pkg::ERR_BAD_TOKEN;
                           sp_ff  <= '0;
                           rsp_ff.error_code  <= pse_pkg::ERR_BAD_TOKEN;
                           rsp_ff.stack_count <= '0;
                        end
                     endcase
                  end
               end
            end
            S_RDB: begin
               opb_ff   <= rd_ff;      // right operand (top)
               state_ff <= S_RDA;
            end
            S_RDA: state_ff <= S_RUN;  // left operand lands in rd_ff
            S_RUN: state_ff <= S_WR;
            S_WR: begin
               // holds here until the ALU finishes; write fires on done with no error
               if (arsp.done) begin
                  if (arsp.err != pse_pkg::ERR_OK) begin
                     err_ff <= arsp.err;
                     sp_ff  <= '0;
                     rsp_ff.error_code  <= arsp.err;
                     rsp_ff.stack_count <= '0;
                  end else begin
                     sp_ff <= sp_ff - PW'(1);
                     rsp_ff.error_code  <= pse_pkg::ERR_OK;
                     rsp_ff.stack_count <= 7'(sp_ff - PW'(1));
                  end
                  state_ff <= S_RSP;
               end
            end
            S_WAIT: begin
               rsp_ff.stack_count <= '0;
               if (err_ff != pse_pkg::ERR_OK) begin
                  rsp_ff.error_code <= err_ff;
               end else if (sp_ff == PW'(1)) begin
                  rsp_ff.error_code   <= pse_pkg::ERR_OK;
                  rsp_ff.result_value <= rd_ff;
               end else begin
                  rsp_ff.error_code <= pse_pkg::ERR_FEW_OPERATORS;
               end
               sp_ff    <= '0;
               err_ff   <= pse_pkg::ERR_OK;
               state_ff <= S_RSP;
            end
            S_RSP: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `PSE_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `PSE_ASSERT_IMPL(a_sp_range, clock, reset, 1'b1, 32'(sp_ff) <= STACK_DEPTH)
   `PSE_ASSERT_NEXT(a_end_clears, clock, reset,
      rsp_valid && rsp_ready && rsp_data.expr_done, sp_ff == '0 && err_ff == '0)

endmodule

// ----- rtl/pse_alu.sv -----
// Shared iterative arithmetic unit: add, sub, mul, div, power.
// Depends on pse_pkg. One 32x32 multiplier, one 33-bit subtractor.
module pse_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  pse_pkg::alu_cmd_type cmd,
   output pse_pkg::alu_rsp_type rsp
);

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_PMUL, S_PSQ, S_DONE} st_type;

   st_type      state_ff, state_in;
   logic [31:0] acc_ff, acc_in;     // quotient / power result
   logic [31:0] rem_ff, rem_in;     // remainder / base
   logic [31:0] opb_ff, opb_in;     // divisor mag / exponent
   logic [31:0] num_ff, num_in;     // dividend shift
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] res_ff, res_in;

   logic [31:0] mag_a, mag_b, mul_x, mul_y, mul_p;
   logic [32:0] trial;
   logic [31:0] rem_sh;

   assign mag_a = cmd.a[31] ? 32'(0 - cmd.a) : cmd.a;
   assign mag_b = cmd.b[31] ? 32'(0 - cmd.b) : cmd.b;
   assign rem_sh = {rem_ff[30:0], num_ff[31]};
   assign trial  = {rem_ff, num_ff[31]} - {1'b0, opb_ff};

   always_comb begin
      mul_x = (state_ff == S_PMUL) ? acc_ff : rem_ff;
      mul_y = rem_ff;
      if (state_ff == S_IDLE) begin
         mul_x = cmd.a;
         mul_y = cmd.b;
      end
   end
   assign mul_p = 32'(mul_x * mul_y);

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff; rem_in = rem_ff; opb_in = opb_ff; num_in = num_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; err_in = err_ff; res_in = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               err_in   = pse_pkg::ERR_OK;
               state_in = S_DONE;
               case (cmd.op)
                  pse_pkg::TK_ADD: res_in = cmd.a + cmd.b;
                  pse_pkg::TK_SUB: res_in = cmd.a - cmd.b;
                  pse_pkg::TK_MUL: res_in = mul_p;
                  pse_pkg::TK_DIV: begin
                     if (cmd.b == '0) begin
                        err_in = pse_pkg::ERR_DIV_ZERO;
                     end else begin
                        num_in = mag_a; opb_in = mag_b; rem_in = '0; acc_in = '0;
                        neg_in = cmd.a[31] ^ cmd.b[31];
                        cnt_in = 6'd32; state_in = S_DIV;
                     end
                  end
                  default: begin
                     if (cmd.a == '0 && cmd.b == '0) begin
                        err_in = pse_pkg::ERR_ZERO_ZERO;
                     end else if (cmd.b[31]) begin
                        if (cmd.a == '0)               err_in = pse_pkg::ERR_DIV_ZERO;
                        else if (cmd.a == 32'd1)       res_in = 32'd1;
                        else if (cmd.a == '1)          res_in = cmd.b[0] ? '1 : 32'd1;
                        else                           res_in = '0;
                     end else begin
                        acc_in = 32'd1; rem_in = cmd.a; opb_in = cmd.b;
                        state_in = S_PMUL;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            num_in = {num_ff[30:0], 1'b0};
            if (!trial[32]) begin
               rem_in = trial[31:0];
               acc_in = {acc_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               acc_in = {acc_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               res_in   = neg_ff ? 32'(0 - acc_in) : acc_in;
               state_in = S_DONE;
            end
         end
         S_PMUL: begin
            if (opb_ff == '0) begin
               res_in   = acc_ff;
               state_in = S_DONE;
            end else begin
               if (opb_ff[0]) acc_in = mul_p;
               state_in = S_PSQ;
            end
         end
         S_PSQ: begin
            rem_in   = mul_p;
            opb_in   = {1'b0, opb_ff[31:1]};
            state_in = S_PMUL;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in; rem_ff <= rem_in; opb_ff <= opb_in; num_ff <= num_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; err_ff <= err_in; res_ff <= res_in;
   end

   assign rsp.done = (state_ff == S_DONE);
   assign rsp.res  = res_ff;
   assign rsp.err  = err_ff;

endmodule
